>>> hdl/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Check an implication whose consequent is due in the next cycle.
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/sha256_pkg.sv
package sha256_pkg;

    localparam int unsigned WordW   = 32;
    localparam int unsigned Rounds  = 64;
    localparam int unsigned BlkWords = 16;

    typedef logic [WordW-1:0] word_t;

    localparam word_t ROUND_K [Rounds] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam word_t INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic word_t rotr(input word_t x, input int unsigned n);
        rotr = (x >> n) | (x << (WordW - n));
    endfunction

    function automatic word_t sig0(input word_t x);
        sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic word_t sig1(input word_t x);
        sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic word_t bsig0(input word_t x);
        bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic word_t bsig1(input word_t x);
        bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

endpackage

>>> hdl/sha256_hash_engine.sv
// SHA-256 hash engine. Feed the message as big-endian 32-bit words on the s_ stream:
// tdata = {byte_count, message_word}, and tlast marks the final word of the message.
// byte_count counts the valid leading bytes and matters only on the last word. Values above 4,
// or any value on a word that is not the last, count as 4. A word that does not complete a
// 16-word block is taken without a stall, and words that are not the last may follow back to
// back. A word that completes a block starts compression with s_tready low: the message
// schedule is extended into the schedule memory, then the rounds run (one round per cycle, the
// schedule word read from the synchronous memory) and the result is folded into the chaining
// hash. After the last word, padding fills the remaining slots of the block. If the 0x80
// word lands in slot 14 or 15, a second padding block follows. Each padding block is then
// compressed. After that come eight digest transactions on m_, H0 first, with tlast on H7.
// s_tready returns the cycle after H7 is taken, and the next message may start then. The
// chaining hash, the round variables and a 16-word schedule window live in flip-flops. The
// block buffer and message schedule live in a 64-entry synchronous memory, written once per
// cycle and read at one address per cycle.
`include "assert_macros.svh"

module sha256_hash_engine (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [31:0] message_word, [34:32] byte_count
    input  logic        s_tlast,   // is_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] digest_word
    output logic        m_tlast    // digest_last
);
    import sha256_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PAD   = 3'd1;
    localparam logic [2:0] ST_SCHED = 3'd2;
    localparam logic [2:0] ST_ROUND = 3'd3;
    localparam logic [2:0] ST_FOLD  = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    // schedule memory: entries 0..63 hold W[t]
    word_t       wmem [Rounds];
    word_t       rd_reg;
    logic [5:0]  raddr;
    logic        we;
    logic [5:0]  waddr;
    word_t       wdata;

    logic [2:0]  state_reg, state_next;
    word_t       h_reg [8];
    word_t       v_reg [8];
    logic [3:0]  pos_reg;
    logic [63:0] bits_reg;
    logic [6:0]  cnt_reg;        // schedule / round counter
    logic        pad_reg;        // 0x80 word still to write
    logic        lenp_reg;       // message end in progress
    logic        xblk_reg;       // length goes into the next block
    logic [2:0]  oidx_reg;
    // taps of the schedule for generation: W[t-16], W[t-15], W[t-7], W[t-2]
    word_t       win_reg [16];

    logic        s_fire, m_fire;
    logic [2:0]  cnt_in;
    word_t       word_in, padw;
    logic        last_in;

    assign s_fire  = s_tvalid && s_tready;
    assign m_fire  = m_tvalid && m_tready;
    assign word_in = s_tdata[31:0];
    assign last_in = s_tlast;
    assign cnt_in  = (!last_in || s_tdata[34:32] > 3'd4) ? 3'd4 : s_tdata[34:32];

    always_comb begin
        unique case (cnt_in)
            3'd0:    padw = 32'h8000_0000;
            3'd1:    padw = {word_in[31:24], 24'h80_0000};
            3'd2:    padw = {word_in[31:16], 16'h8000};
            3'd3:    padw = {word_in[31:8], 8'h80};
            default: padw = word_in;
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = h_reg[oidx_reg];
    assign m_tlast  = (oidx_reg == 3'd7);

    // round inputs
    word_t t1, t2, wt;
    assign wt = rd_reg;
    always_comb begin
        t1 = v_reg[7] + bsig1(v_reg[4]) + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
           + ROUND_K[cnt_reg[5:0] - 6'd1] + wt;
        t2 = bsig0(v_reg[0]) + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2])
           ^ (v_reg[1] & v_reg[2]));
    end

    // write port selection
    always_comb begin
        we    = 1'b0;
        waddr = {2'b00, pos_reg};
        wdata = word_in;
        unique case (state_reg)
            ST_IDLE: begin
                we    = s_fire;
                wdata = last_in ? (cnt_in == 3'd4 ? word_in : padw) : word_in;
            end
            ST_PAD: begin
                we = 1'b1;
                if (pad_reg) begin
                    wdata = 32'h8000_0000;
                end else if (!xblk_reg && pos_reg == 4'd14) begin
                    wdata = bits_reg[63:32];
                end else if (!xblk_reg && pos_reg == 4'd15) begin
                    wdata = bits_reg[31:0];
                end else begin
                    wdata = '0;
                end
            end
            ST_SCHED: begin
                we    = 1'b1;
                waddr = cnt_reg[5:0] + 6'd16;
                wdata = win_reg[0] + sig0(win_reg[1]) + win_reg[9] + sig1(win_reg[14]);
            end
            default: we = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            wmem[waddr] <= wdata;
        end
        rd_reg <= wmem[raddr];
    end

    always_comb begin
        raddr = '0;
        if (state_reg == ST_SCHED && cnt_reg == 7'd47) begin
            raddr = 6'd0;
        end else if (state_reg == ST_ROUND) begin
            raddr = cnt_reg[5:0];
        end else begin
            raddr = cnt_reg[5:0];
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_fire) begin
                if (pos_reg == 4'd15) begin
                    state_next = ST_SCHED;
                end else if (last_in) begin
                    state_next = ST_PAD;
                end
            end
            ST_PAD:   if (pos_reg == 4'd15) state_next = ST_SCHED;
            ST_SCHED: if (cnt_reg == 7'd47) state_next = ST_ROUND;
            ST_ROUND: if (cnt_reg == 7'd64) state_next = ST_FOLD;
            ST_FOLD:  state_next = !lenp_reg ? ST_IDLE
                                 : ((pad_reg || xblk_reg) ? ST_PAD : ST_OUT);
            ST_OUT:   if (m_fire && oidx_reg == 3'd7) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // window of the 16 most recent schedule words; the writes of the block fill it too
    logic win_shift;
    assign win_shift = we;

    always_ff @(posedge aclk) begin
        if (win_shift) begin
            for (int i = 0; i < 15; i++) begin
                win_reg[i] <= win_reg[i+1];
            end
            win_reg[15] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pos_reg   <= '0;
            bits_reg  <= '0;
            cnt_reg   <= '0;
            pad_reg   <= 1'b0;
            lenp_reg  <= 1'b0;
            xblk_reg  <= 1'b0;
            oidx_reg  <= '0;
            for (int i = 0; i < 8; i++) h_reg[i] <= INIT_H[i];
        end else begin
            state_reg <= state_next;
            unique case (state_reg)
                ST_IDLE: if (s_fire) begin
                    bits_reg <= bits_reg + {58'd0, cnt_in, 3'd0};
                    pos_reg  <= pos_reg + 4'd1;
                    cnt_reg  <= '0;
                    if (last_in) begin
                        // full last word still needs its 0x80 word
                        pad_reg  <= (cnt_in == 3'd4);
                        lenp_reg <= 1'b1;
                        // 0x80 word in slot 14 or 15 leaves no room for the length
                        xblk_reg <= (cnt_in != 3'd4) && (pos_reg >= 4'd14);
                    end
                end
                ST_PAD: begin
                    pos_reg <= pos_reg + 4'd1;
                    cnt_reg <= '0;
                    if (pad_reg) begin
                        pad_reg <= 1'b0;
                        if (pos_reg >= 4'd14) xblk_reg <= 1'b1;
                    end
                end
                ST_SCHED: begin
                    cnt_reg <= (cnt_reg == 7'd47) ? 7'd1 : cnt_reg + 7'd1;
                    if (cnt_reg == 7'd47) begin
                        for (int i = 0; i < 8; i++) v_reg[i] <= h_reg[i];
                    end
                end
                ST_ROUND: begin
                    cnt_reg <= cnt_reg + 7'd1;
                    v_reg[7] <= v_reg[6];
                    v_reg[6] <= v_reg[5];
                    v_reg[5] <= v_reg[4];
                    v_reg[4] <= v_reg[3] + t1;
                    v_reg[3] <= v_reg[2];
                    v_reg[2] <= v_reg[1];
                    v_reg[1] <= v_reg[0];
                    v_reg[0] <= t1 + t2;
                end
                ST_FOLD: begin
                    for (int i = 0; i < 8; i++) h_reg[i] <= h_reg[i] + v_reg[i];
                    xblk_reg <= 1'b0;
                end
                ST_OUT: if (m_fire) begin
                    oidx_reg <= oidx_reg + 3'd1;
                    if (oidx_reg == 3'd7) begin
                        for (int i = 0; i < 8; i++) h_reg[i] <= INIT_H[i];
                        bits_reg <= '0;
                        pos_reg  <= '0;
                        lenp_reg <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "digest transaction changed while stalled")
    `ASSERT_IMPL(a_in_out_excl, aclk, aresetn, s_tready, !m_tvalid, "input and output open together")
    `ASSERT_NEXT(a_ready_after_digest, aclk, aresetn, m_tvalid && m_tready && m_tlast, s_tready, "input not reopened after digest")
endmodule
